@@ sv/bpa_pkg.sv @@
// ----------------------------------------------------------------------------
// Bitmap page allocator package
// Shared constants, types and register indexes for the page allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bpa_pkg;

    localparam int NUM_REGIONS      = 2;
    localparam int MAX_REGIONS      = 2;
    localparam int PAGES_PER_REGION = 4096;
    localparam int PAGE_SHIFT       = 12;

    localparam int ADDR_WIDTH  = 48;
    localparam int PAGES_WIDTH = 13;
    localparam int CFG_INDEX_W = 3;
    localparam int REGION_W    = 1;

    // Bitmap geometry: 32 pages per word.
    localparam int WORDS_PER_REGION = (PAGES_PER_REGION + 31) / 32;
    localparam int WORD_W  = (WORDS_PER_REGION > 1) ? $clog2(WORDS_PER_REGION) : 1;
    localparam int IDX_W   = WORD_W + 5;
    localparam int RAM_AW  = REGION_W + WORD_W;
    localparam int RAM_DEPTH = 2 ** RAM_AW;

    // Largest page count a region can track, within the width of its register.
    localparam int PAGES_MAX = (1 << PAGES_WIDTH) - 1;
    localparam int PAGE_CAP  = (PAGES_PER_REGION > PAGES_MAX) ? PAGES_MAX : PAGES_PER_REGION;

    typedef logic [ADDR_WIDTH-1:0]  addr_t;
    typedef logic [PAGES_WIDTH-1:0] pages_t;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    localparam cfg_index_t REG_R0_BASE  = 3'd0;
    localparam cfg_index_t REG_R0_END   = 3'd1;
    localparam cfg_index_t REG_R0_PAGES = 3'd2;
    localparam cfg_index_t REG_R1_BASE  = 3'd3;
    localparam cfg_index_t REG_R1_END   = 3'd4;
    localparam cfg_index_t REG_R1_PAGES = 3'd5;

endpackage

`default_nettype wire

@@ sv/bpa_ram.sv @@
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module bpa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

@@ sv/bitmap_page_allocator.sv @@
// ----------------------------------------------------------------------------
// Bitmap page allocator
// First-fit physical page allocator over two regions with used-page bitmaps.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. busy then stays high
// until the cycle in which the single result is shown, and it is low in that
// cycle. The result appears on ok and address, which hold it until the next
// result, and done marks it for exactly one cycle; the receiver cannot stall
// it. An allocate request walks the bitmap one 32-bit word per cycle through
// the read port of the bitmap RAM, region zero first and then region one, and
// it pauses the walk while it steps from one region to the next. It checks
// each word as it arrives and, on the first free page, writes the word back
// with that page marked used. A failed allocate ends once every tracked word
// of both regions has been checked. A free request goes through range match,
// index check, read and write back of one bitmap word, and a free that fails
// ends before the read. In every case the result is shown in the cycle right
// after the last busy cycle. After reset the block runs a clearing pass over
// all 256 bitmap words, one per cycle, and holds busy high throughout that
// pass; configuration writes are accepted throughout, including during that
// pass. Configuration should only be written while no request is in
// progress.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_page_allocator (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // Request channel
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic                            operation,
    input  wire logic [bpa_pkg::ADDR_WIDTH-1:0]  page_address,
    // Result channel
    output logic                                 done,
    output logic                                 ok,
    output logic      [bpa_pkg::ADDR_WIDTH-1:0]  address,
    // Configuration write channel
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [bpa_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [bpa_pkg::ADDR_WIDTH-1:0]  cfg_data
);

    // Sequencer states.
    localparam logic [2:0] ST_CLEAR   = 3'd0;
    localparam logic [2:0] ST_IDLE    = 3'd1;
    localparam logic [2:0] ST_A_SCAN  = 3'd2;
    localparam logic [2:0] ST_A_WR    = 3'd3;
    localparam logic [2:0] ST_F_MATCH = 3'd4;
    localparam logic [2:0] ST_F_IDX   = 3'd5;
    localparam logic [2:0] ST_F_RD    = 3'd6;
    localparam logic [2:0] ST_F_WR    = 3'd7;

    localparam int WORD_W   = bpa_pkg::WORD_W;
    localparam int IDX_W    = bpa_pkg::IDX_W;
    localparam int RAM_AW   = bpa_pkg::RAM_AW;
    localparam int REGION_W = bpa_pkg::REGION_W;

    localparam logic [REGION_W-1:0] LAST_REGION = REGION_W'(bpa_pkg::NUM_REGIONS - 1);

    // The value of the page count register is clamped to the bitmap capacity.
    function automatic bpa_pkg::pages_t tracked_of(input bpa_pkg::pages_t p);
        if (32'(p) > 32'(bpa_pkg::PAGE_CAP))
        begin
            return bpa_pkg::PAGES_WIDTH'(bpa_pkg::PAGE_CAP);
        end
        return p;
    endfunction

    // Number of bitmap words that hold tracked pages.
    function automatic logic [WORD_W:0] words_of(input bpa_pkg::pages_t t);
        logic [bpa_pkg::PAGES_WIDTH:0] sum;
        sum = {1'b0, t} + (bpa_pkg::PAGES_WIDTH + 1)'(31);
        return (WORD_W + 1)'(sum >> 5);
    endfunction

    // Configuration registers.
    bpa_pkg::addr_t  base_reg  [bpa_pkg::MAX_REGIONS];
    bpa_pkg::addr_t  end_reg   [bpa_pkg::MAX_REGIONS];
    bpa_pkg::pages_t pages_reg [bpa_pkg::MAX_REGIONS];

    // Sequencer state.
    logic [2:0]          state_reg, state_next;
    logic [RAM_AW-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [REGION_W-1:0] iss_r_reg, iss_r_next;
    logic [WORD_W:0]     iss_w_reg, iss_w_next;
    logic                iss_done_reg, iss_done_next;
    logic                chk_vld_reg, chk_vld_next;
    logic [REGION_W-1:0] chk_r_reg, chk_r_next;
    logic [WORD_W-1:0]   chk_w_reg, chk_w_next;
    logic [REGION_W-1:0] sel_r_reg, sel_r_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [31:0]         wr_data_reg, wr_data_next;
    bpa_pkg::addr_t      req_addr_reg, req_addr_next;

    // Result registers.
    logic                done_reg, done_next;
    logic                ok_reg, ok_next;
    bpa_pkg::addr_t      address_reg, address_next;

    // Bitmap RAM port signals.
    logic                ram_we;
    logic [RAM_AW-1:0]   ram_waddr;
    logic [31:0]         ram_wdata;
    logic                ram_re;
    logic [RAM_AW-1:0]   ram_raddr;
    logic [31:0]         ram_rdata;

    // Datapath signals.
    bpa_pkg::pages_t     iss_tracked;
    logic [WORD_W:0]     iss_words;
    bpa_pkg::pages_t     chk_tracked;
    bpa_pkg::pages_t     sel_tracked;
    logic [31:0]         limit;
    logic [31:0]         used_mask;
    logic [31:0]         masked_word;
    logic                zero_found;
    logic [4:0]          zero_pos;
    logic                range_hit;
    bpa_pkg::addr_t      offset;
    bpa_pkg::addr_t      page_index;
    bpa_pkg::addr_t      alloc_address;
    logic [RAM_AW-1:0]   word_addr;

    bpa_ram #(
        .WIDTH (32),
        .DEPTH (bpa_pkg::RAM_DEPTH)
    ) u_bitmap (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cfg_ready = 1'b1;
    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign ok        = ok_reg;
    assign address   = address_reg;

    // Configuration writes; indexes beyond the list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < bpa_pkg::MAX_REGIONS; r++)
            begin
                base_reg[r]  <= '0;
                end_reg[r]   <= '0;
                pages_reg[r] <= '0;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                bpa_pkg::REG_R0_BASE:  base_reg[0]  <= cfg_data;
                bpa_pkg::REG_R0_END:   end_reg[0]   <= cfg_data;
                bpa_pkg::REG_R0_PAGES: pages_reg[0] <= cfg_data[bpa_pkg::PAGES_WIDTH-1:0];
                bpa_pkg::REG_R1_BASE:  base_reg[1]  <= cfg_data;
                bpa_pkg::REG_R1_END:   end_reg[1]   <= cfg_data;
                bpa_pkg::REG_R1_PAGES: pages_reg[1] <= cfg_data[bpa_pkg::PAGES_WIDTH-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // The issue side of the scan walks words of the current region.
    assign iss_tracked = tracked_of(pages_reg[iss_r_reg]);
    assign iss_words   = words_of(iss_tracked);

    // The check side looks at the word read in the previous cycle. Bits for
    // pages past the tracked count are treated as used.
    assign chk_tracked = tracked_of(pages_reg[chk_r_reg]);
    assign limit       = 32'(chk_tracked) - (32'(chk_w_reg) << 5);
    assign used_mask   = (limit >= 32'd32) ? 32'd0 : ~((32'd1 << limit[4:0]) - 32'd1);
    assign masked_word = ram_rdata | used_mask;

    // Lowest clear bit of the checked word.
    always_comb
    begin
        zero_found = 1'b0;
        zero_pos   = '0;
        for (int i = 31; i >= 0; i--)
        begin
            if (!masked_word[i])
            begin
                zero_found = 1'b1;
                zero_pos   = 5'(i);
            end
        end
    end

    // Shared address arithmetic for the selected region.
    assign sel_tracked   = tracked_of(pages_reg[sel_r_reg]);
    assign range_hit     = (base_reg[sel_r_reg] <= req_addr_reg) &&
                           (req_addr_reg < end_reg[sel_r_reg]);
    assign offset        = req_addr_reg - base_reg[sel_r_reg];
    assign page_index    = offset >> bpa_pkg::PAGE_SHIFT;
    assign alloc_address = base_reg[sel_r_reg] +
                           (bpa_pkg::ADDR_WIDTH'(idx_reg) << bpa_pkg::PAGE_SHIFT);
    assign word_addr     = {sel_r_reg, idx_reg[IDX_W-1:5]};

    always_comb
    begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        iss_r_next    = iss_r_reg;
        iss_w_next    = iss_w_reg;
        iss_done_next = iss_done_reg;
        chk_vld_next  = 1'b0;
        chk_r_next    = chk_r_reg;
        chk_w_next    = chk_w_reg;
        sel_r_next    = sel_r_reg;
        idx_next      = idx_reg;
        wr_data_next  = wr_data_reg;
        req_addr_next = req_addr_reg;
        done_next     = 1'b0;
        ok_next       = ok_reg;
        address_next  = address_reg;

        ram_we    = 1'b0;
        ram_waddr = word_addr;
        ram_wdata = wr_data_reg;
        ram_re    = 1'b0;
        ram_raddr = {iss_r_reg, iss_w_reg[WORD_W-1:0]};

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (start)
                begin
                    req_addr_next = page_address;
                    iss_r_next    = '0;
                    iss_w_next    = '0;
                    iss_done_next = 1'b0;
                    sel_r_next    = '0;
                    state_next    = operation ? ST_F_MATCH : ST_A_SCAN;
                end
            end

            ST_A_SCAN:
            begin
                // Issue the next word read, or step to the next region.
                if (!iss_done_reg)
                begin
                    if (iss_w_reg < iss_words)
                    begin
                        ram_re       = 1'b1;
                        chk_vld_next = 1'b1;
                        chk_r_next   = iss_r_reg;
                        chk_w_next   = iss_w_reg[WORD_W-1:0];
                        iss_w_next   = iss_w_reg + 1'b1;
                    end
                    else if (iss_r_reg == LAST_REGION)
                    begin
                        iss_done_next = 1'b1;
                    end
                    else
                    begin
                        iss_r_next = iss_r_reg + 1'b1;
                        iss_w_next = '0;
                    end
                end

                // Check the word that arrived from the previous read.
                if (chk_vld_reg && zero_found)
                begin
                    sel_r_next   = chk_r_reg;
                    idx_next     = {chk_w_reg, zero_pos};
                    wr_data_next = ram_rdata | (32'd1 << zero_pos);
                    state_next   = ST_A_WR;
                end
                else if (iss_done_reg && !chk_vld_reg)
                begin
                    done_next    = 1'b1;
                    ok_next      = 1'b0;
                    address_next = '0;
                    state_next   = ST_IDLE;
                end
            end

            ST_A_WR:
            begin
                ram_we       = 1'b1;
                done_next    = 1'b1;
                ok_next      = 1'b1;
                address_next = alloc_address;
                state_next   = ST_IDLE;
            end

            ST_F_MATCH:
            begin
                if (range_hit)
                begin
                    state_next = ST_F_IDX;
                end
                else if (sel_r_reg == LAST_REGION)
                begin
                    done_next    = 1'b1;
                    ok_next      = 1'b0;
                    address_next = '0;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    sel_r_next = sel_r_reg + 1'b1;
                end
            end

            ST_F_IDX:
            begin
                // The first matching region decides, even when the index is out of range.
                if (page_index < bpa_pkg::ADDR_WIDTH'(sel_tracked))
                begin
                    idx_next   = page_index[IDX_W-1:0];
                    state_next = ST_F_RD;
                end
                else
                begin
                    done_next    = 1'b1;
                    ok_next      = 1'b0;
                    address_next = '0;
                    state_next   = ST_IDLE;
                end
            end

            ST_F_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = word_addr;
                state_next = ST_F_WR;
            end

            ST_F_WR:
            begin
                ram_we       = 1'b1;
                ram_wdata    = ram_rdata & ~(32'd1 << idx_reg[4:0]);
                done_next    = 1'b1;
                ok_next      = 1'b1;
                address_next = '0;
                state_next   = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            iss_done_reg <= 1'b0;
            chk_vld_reg  <= 1'b0;
            done_reg     <= 1'b0;
            ok_reg       <= 1'b0;
            address_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            iss_done_reg <= iss_done_next;
            chk_vld_reg  <= chk_vld_next;
            done_reg     <= done_next;
            ok_reg       <= ok_next;
            address_reg  <= address_next;
        end
    end

    always_ff @(posedge clk)
    begin
        iss_r_reg    <= iss_r_next;
        iss_w_reg    <= iss_w_next;
        chk_r_reg    <= chk_r_next;
        chk_w_reg    <= chk_w_next;
        sel_r_reg    <= sel_r_next;
        idx_reg      <= idx_next;
        wr_data_reg  <= wr_data_next;
        req_addr_reg <= req_addr_next;
    end

endmodule

`default_nettype wire

@@ sv/bpa_checker.sv @@
// ----------------------------------------------------------------------------
// Bitmap page allocator checker
// Port-level assertions on request and result timing, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bpa_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           start,
    input wire logic                           busy,
    input wire logic                           done,
    input wire logic                           ok,
    input wire logic [bpa_pkg::ADDR_WIDTH-1:0] address
);

    // An accepted request always occupies the block for the following cycle.
    a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after a request was taken");

    // A result is shown only once the block is ready for the next request.
    a_idle_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while still busy");

    // Each request gives a single result, never two in a row.
    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

    // A failed request carries a zero address.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !ok) |-> (address == '0))
        else $error("failed request returned a non-zero address");

endmodule

bind bitmap_page_allocator bpa_checker u_bpa_checker (.*);

`default_nettype wire

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// Bitmap page allocator testbench
// Drives allocate and free requests into the first-fit page allocator, keeps
// its own model of both region bitmaps and checks every result in order.
// ----------------------------------------------------------------------------
module testbench;

    // Request operations as carried on the operation port.
    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } page_op_t;

    // Register indexes that the block decodes to nothing.
    localparam bpa_pkg::cfg_index_t REG_SPARE_LO = 3'd6;
    localparam bpa_pkg::cfg_index_t REG_SPARE_HI = 3'd7;

    localparam int RANDOM_REQUESTS = 800;
    localparam int SETTLE_CYCLES   = 300;

    typedef struct packed {
        page_op_t       op;
        bpa_pkg::addr_t where;
    } page_req_t;

    typedef struct packed {
        logic           ok;
        bpa_pkg::addr_t address;
    } page_result_t;

    // Clock, reset and the ports of the block. Every input has a known value
    // from time zero.
    logic                clk;
    logic                rst_n        = 1'b0;
    logic                start        = 1'b0;
    logic                operation    = OP_ALLOC;
    bpa_pkg::addr_t      page_address = '0;
    logic                cfg_valid    = 1'b0;
    bpa_pkg::cfg_index_t cfg_index    = bpa_pkg::REG_R0_BASE;
    bpa_pkg::addr_t      cfg_data     = '0;
    logic                busy;
    logic                done;
    logic                ok;
    bpa_pkg::addr_t      address;
    logic                cfg_ready;

    // Requests waiting to be sent, and the results that accepted requests owe.
    page_req_t    pending_req[$];
    page_result_t owed_result[$];
    int           mismatch_count = 0;

    // Own copy of the register file and of the used-page bitmaps.
    bpa_pkg::addr_t  region_base  [bpa_pkg::MAX_REGIONS] = '{default: '0};
    bpa_pkg::addr_t  region_limit [bpa_pkg::MAX_REGIONS] = '{default: '0};
    bpa_pkg::pages_t region_pages [bpa_pkg::MAX_REGIONS] = '{default: '0};
    bit              page_used    [bpa_pkg::MAX_REGIONS][bpa_pkg::PAGES_PER_REGION];

    // Region layout chosen by the stimulus for the next configuration phase.
    // The page count is held at full data width so that junk above the
    // register width can be written too.
    bpa_pkg::addr_t plan_base  [bpa_pkg::MAX_REGIONS];
    bpa_pkg::addr_t plan_top   [bpa_pkg::MAX_REGIONS];
    bpa_pkg::addr_t plan_pages [bpa_pkg::MAX_REGIONS];

    // Sender pacing: the gap before the next request and whether the sender is
    // currently in a stretch with no gaps at all.
    int gap_left = 0;
    bit steady   = 1'b0;

    bitmap_page_allocator DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operation    (operation),
        .page_address (page_address),
        .done         (done),
        .ok           (ok),
        .address      (address),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // A generous ceiling: several times the slowest correct run, in which every
    // allocate scans both full bitmaps and every request waits its longest gap.
    initial
    begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Page counts above the bitmap capacity behave as the full capacity.
    // ------------------------------------------------------------------------
    function automatic int clamp_pages(bpa_pkg::pages_t count);
        return (count > bpa_pkg::PAGES_PER_REGION) ? bpa_pkg::PAGES_PER_REGION : int'(count);
    endfunction

    // ------------------------------------------------------------------------
    // Works out the result of one request and updates the bitmap copy. An
    // allocate takes the lowest free page of region zero, then of region one.
    // A free is decided by the first region whose range holds the address;
    // an index past that region's page count fails and no later region is
    // tried. Allocated addresses wrap at the address width.
    // ------------------------------------------------------------------------
    function automatic page_result_t serve_request(page_op_t op, bpa_pkg::addr_t where);
        page_result_t   res;
        int             count;
        bpa_pkg::addr_t index;
        res = '{ok: 1'b0, address: '0};
        if (op == OP_ALLOC)
        begin
            for (int r = 0; r < bpa_pkg::NUM_REGIONS && !res.ok; r++)
            begin
                count = clamp_pages(region_pages[r]);
                for (int i = 0; i < count; i++)
                begin
                    if (!page_used[r][i])
                    begin
                        page_used[r][i] = 1'b1;
                        res.ok          = 1'b1;
                        res.address     = region_base[r]
                                          + (bpa_pkg::addr_t'(i) << bpa_pkg::PAGE_SHIFT);
                        break;
                    end
                end
            end
        end
        else
        begin
            for (int r = 0; r < bpa_pkg::NUM_REGIONS; r++)
            begin
                if (region_base[r] <= where && where < region_limit[r])
                begin
                    count = clamp_pages(region_pages[r]);
                    index = (where - region_base[r]) >> bpa_pkg::PAGE_SHIFT;
                    if (index < bpa_pkg::addr_t'(count))
                    begin
                        // Freeing a page that is already free still succeeds.
                        page_used[r][int'(index)] = 1'b0;
                        res.ok = 1'b1;
                    end
                    break;
                end
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(string what);
        $display("MISMATCH at %0t: %s", $time, what);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------------
    // Configuration register copy, updated on each accepted write. Writes to
    // the spare indexes change nothing; the page count keeps only the low bits.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                bpa_pkg::REG_R0_BASE:  region_base[0]  = cfg_data;
                bpa_pkg::REG_R0_END:   region_limit[0] = cfg_data;
                bpa_pkg::REG_R0_PAGES: region_pages[0] = cfg_data[bpa_pkg::PAGES_WIDTH-1:0];
                bpa_pkg::REG_R1_BASE:  region_base[1]  = cfg_data;
                bpa_pkg::REG_R1_END:   region_limit[1] = cfg_data;
                bpa_pkg::REG_R1_PAGES: region_pages[1] = cfg_data[bpa_pkg::PAGES_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Request driver. A request is taken at an edge where start is high and
    // busy is low; its result is predicted there and then. After each accepted
    // request the sender draws a random gap before the next one, except in steady
    // stretches where it sends back to back. start is assigned at most once
    // per edge, so a request that follows with no gap keeps start high.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : request_driver
        page_req_t next_req;
        if (!rst_n)
        begin
            start        <= 1'b0;
            operation    <= OP_ALLOC;
            page_address <= '0;
            gap_left     = 0;
        end
        else
        begin
            if (start && !busy)
            begin
                owed_result.push_back(serve_request(page_op_t'(operation), page_address));
                if ($urandom_range(0, 39) == 0)
                    steady = !steady;
                gap_left = steady ? 0 : $urandom_range(0, 4);
            end
            // The channel is free after this edge unless a request is still
            // waiting for busy to fall.
            if (!start || !busy)
            begin
                if (gap_left == 0 && pending_req.size() != 0)
                begin
                    next_req = pending_req.pop_front();
                    start        <= 1'b1;
                    operation    <= next_req.op;
                    page_address <= next_req.where;
                end
                else
                begin
                    start <= 1'b0;
                    if (gap_left > 0)
                        gap_left--;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor. done marks a result for exactly one cycle and cannot be
    // held off, so every edge with done high carries one result, compared
    // with the oldest one owed.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        page_result_t want;
        if (rst_n && done)
        begin
            if (owed_result.size() == 0)
            begin
                report_mismatch($sformatf("result with no request owed: ok=%0b address=%h",
                                          ok, address));
            end
            else
            begin
                want = owed_result.pop_front();
                if (ok !== want.ok)
                    report_mismatch($sformatf("ok is %0b, expected %0b", ok, want.ok));
                if (address !== want.address)
                    report_mismatch($sformatf("address is %h, expected %h",
                                              address, want.address));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    task automatic cfg_write(bpa_pkg::cfg_index_t index, bpa_pkg::addr_t data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Waits until every queued request has been sent and every result has
    // come back, so that the block is idle.
    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending_req.size() != 0 || start || busy || owed_result.size() != 0);
    endtask

    task automatic program_plan();
        cfg_write(bpa_pkg::REG_R0_BASE,  plan_base[0]);
        cfg_write(bpa_pkg::REG_R0_END,   plan_top[0]);
        cfg_write(bpa_pkg::REG_R0_PAGES, plan_pages[0]);
        cfg_write(bpa_pkg::REG_R1_BASE,  plan_base[1]);
        cfg_write(bpa_pkg::REG_R1_END,   plan_top[1]);
        cfg_write(bpa_pkg::REG_R1_PAGES, plan_pages[1]);
    endtask

    task automatic queue_request(page_op_t op, bpa_pkg::addr_t where);
        pending_req.push_back('{op: op, where: where});
    endtask

    // ------------------------------------------------------------------------
    // Main sequence: reset, a directed part through the special cases, then
    // random phases, each with its own region layout and mix of requests.
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int             random_sent;
        int             burst;
        int             alloc_share;
        int             r;
        int             room;
        bpa_pkg::addr_t where;

        random_sent = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // With every register at reset no page is tracked and no region
        // matches, so all three requests fail.
        queue_request(OP_ALLOC, '0);
        queue_request(OP_FREE, '0);
        queue_request(OP_FREE, '1);
        wait_idle();

        // Region zero sits at the very top of the address space so that its
        // later pages wrap round to zero; region one is small and low.
        plan_base[0]  = 48'hFFFF_FFFF_E000;
        plan_top[0]   = 48'hFFFF_FFFF_FFFF;
        plan_pages[0] = 48'd4;
        plan_base[1]  = 48'h0000_0010_0000;
        plan_top[1]   = 48'h0000_0010_3000;
        plan_pages[1] = 48'd2;
        program_plan();
        // Writes to the spare indexes must leave the registers alone.
        cfg_write(REG_SPARE_LO, '1);
        cfg_write(REG_SPARE_HI, '0);
        repeat (4) queue_request(OP_ALLOC, '0);     // last two wrap past the top
        repeat (2) queue_request(OP_ALLOC, '1);     // spill into region one
        queue_request(OP_ALLOC, '0);                 // both regions full
        queue_request(OP_FREE, 48'h0000_0010_1FFF);  // unaligned, page one
        queue_request(OP_FREE, 48'h0000_0010_2000);  // in range, past the page count
        queue_request(OP_ALLOC, '0);
        queue_request(OP_FREE, 48'hFFFF_FFFF_E123);
        queue_request(OP_FREE, 48'hFFFF_FFFF_E123);  // page already free
        queue_request(OP_FREE, 48'hFFFF_FFFF_FFFF);  // the end address itself
        queue_request(OP_ALLOC, '0);
        wait_idle();

        // Region zero inverted and given a page count above capacity; region
        // one takes its page count from data with junk in the upper bits.
        plan_base[0]  = 48'h0000_0000_5000;
        plan_top[0]   = 48'h0000_0000_4000;
        plan_pages[0] = 48'h0000_0000_1FFF;
        plan_base[1]  = '0;
        plan_top[1]   = 48'h0000_0001_0000;
        plan_pages[1] = 48'hFFFF_FFFF_F000 | 48'(bpa_pkg::PAGES_PER_REGION);
        program_plan();
        queue_request(OP_FREE, 48'h0000_0000_5000);  // skips the inverted region
        queue_request(OP_ALLOC, '0);
        wait_idle();

        // Overlapping regions: the first match decides even when it fails.
        plan_base[0]  = '0;
        plan_top[0]   = 48'h0000_0010_0000;
        plan_pages[0] = 48'd2;
        plan_base[1]  = '0;
        plan_top[1]   = 48'h0000_0020_0000;
        plan_pages[1] = 48'd100;
        program_plan();
        queue_request(OP_FREE, 48'h0000_0000_3000);
        queue_request(OP_FREE, 48'h0000_0000_1000);
        queue_request(OP_ALLOC, '0);
        queue_request(OP_ALLOC, '0);
        wait_idle();

        // Random phases. Most layouts are well formed, with end just past the
        // last tracked page and small page counts so that regions fill up and
        // allocation overflows into region one; the rest use the extreme page
        // counts, empty, inverted or random ranges and overlapping bases.
        while (random_sent < RANDOM_REQUESTS)
        begin
            for (int k = 0; k < bpa_pkg::MAX_REGIONS; k++)
            begin
                case ($urandom_range(0, 9))
                    0:       plan_pages[k] = '0;
                    1:       plan_pages[k] = bpa_pkg::addr_t'(bpa_pkg::PAGES_PER_REGION);
                    2:       plan_pages[k] = bpa_pkg::addr_t'((1 << bpa_pkg::PAGES_WIDTH) - 1);
                    3:       plan_pages[k] = bpa_pkg::addr_t'({$urandom(), $urandom()});
                    default: plan_pages[k] = bpa_pkg::addr_t'($urandom_range(1, 40));
                endcase
                if ($urandom_range(0, 1) == 0)
                    plan_base[k] = bpa_pkg::addr_t'($urandom_range(0, 255)) << 20;
                else
                    plan_base[k] = bpa_pkg::addr_t'({$urandom(), $urandom()});
                if ($urandom_range(0, 3) != 0)
                    plan_base[k][bpa_pkg::PAGE_SHIFT-1:0] = '0;
                room = clamp_pages(plan_pages[k][bpa_pkg::PAGES_WIDTH-1:0]);
                case ($urandom_range(0, 7))
                    0: plan_top[k] = plan_base[k];
                    1: plan_top[k] = bpa_pkg::addr_t'({$urandom(), $urandom()});
                    2: plan_top[k] = '1;
                    3: plan_top[k] = plan_base[k]
                                     + (bpa_pkg::addr_t'(room) << bpa_pkg::PAGE_SHIFT)
                                     + bpa_pkg::addr_t'($urandom_range(0,
                                                        3 << bpa_pkg::PAGE_SHIFT));
                    default: plan_top[k] = plan_base[k]
                                           + (bpa_pkg::addr_t'(room) << bpa_pkg::PAGE_SHIFT);
                endcase
            end
            if ($urandom_range(0, 4) == 0)
                plan_base[1] = plan_base[0];
            program_plan();
            if ($urandom_range(0, 5) == 0)
                cfg_write($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
                          bpa_pkg::addr_t'({$urandom(), $urandom()}));

            burst       = $urandom_range(20, 60);
            alloc_share = $urandom_range(30, 80);
            for (int n = 0; n < burst; n++)
            begin
                // Now and then the sender holds off mid-phase until every
                // outstanding result is back.
                if (n == burst / 2 && $urandom_range(0, 3) == 0)
                    wait_idle();
                if ($urandom_range(1, 100) <= alloc_share)
                begin
                    queue_request(OP_ALLOC, bpa_pkg::addr_t'({$urandom(), $urandom()}));
                end
                else
                begin
                    r    = $urandom_range(0, bpa_pkg::MAX_REGIONS - 1);
                    room = clamp_pages(plan_pages[r][bpa_pkg::PAGES_WIDTH-1:0]);
                    case ($urandom_range(0, 9))
                        0: where = bpa_pkg::addr_t'({$urandom(), $urandom()});
                        1: where = plan_base[r] - 1'b1;
                        2: where = plan_top[r];
                        3: where = plan_top[r] - 1'b1;
                        default:
                        begin
                            where = plan_base[r]
                                    + (bpa_pkg::addr_t'($urandom_range(0, room + 1))
                                       << bpa_pkg::PAGE_SHIFT);
                            if ($urandom_range(0, 1) == 0)
                                where = where
                                        + bpa_pkg::addr_t'($urandom_range(0,
                                          (1 << bpa_pkg::PAGE_SHIFT) - 1));
                        end
                    endcase
                    queue_request(OP_FREE, where);
                end
                random_sent++;
            end
            wait_idle();
        end

        // Let the block settle in case a stray result is still to come.
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (owed_result.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", owed_result.size()));

        if (mismatch_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
